[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, left empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/pisuc_pkg.sv]
// ----------------------------------------------------------------------------
// pisuc_pkg
// types and constants of the point-in-sphere-union counter
// ----------------------------------------------------------------------------
`default_nettype none

package pisuc_pkg;

  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int SLOT_W      = 6;
  localparam int CFG_W       = 7;
  localparam int CNT_W       = 32;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // action codes
  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActTest  = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;
  localparam logic [1:0] ActSpare = 2'd3;

  // register word index
  localparam logic RegSphereCount = 1'b0;

  typedef struct packed {
    logic [1:0]                    action;
    logic [SLOT_W-1:0]             slot;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic [RADIUS_BITS-1:0]        radius;
  } item_t;

  typedef struct packed {
    logic              inside_res;
    logic [SLOT_W-1:0] hit_slot;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  point_count;
  } result_t;

  // one table entry as stored in the sphere memory
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [RADIUS_BITS-1:0]       r;
  } sphere_t;

  // tag travelling with a table read into the distance pipe
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] tag;
  } stage_t;

  // status back from the distance pipe
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] tag;
    logic              pending;
  } dist_res_t;

endpackage

`default_nettype wire

[hw/rtl/pisuc_ram.sv]
// ----------------------------------------------------------------------------
// pisuc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pisuc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pisuc_dist.sv]
// ----------------------------------------------------------------------------
// pisuc_dist
// distance pipe: absolute deltas, squares, then sum and compare with r squared
// ----------------------------------------------------------------------------
`default_nettype none

module pisuc_dist
  import pisuc_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         flush_i,
  input  wire stage_t                       in_i,
  input  wire sphere_t                      sphere_i,
  input  wire logic signed [COORD_BITS-1:0] px_i,
  input  wire logic signed [COORD_BITS-1:0] py_i,
  input  wire logic signed [COORD_BITS-1:0] pz_i,
  output dist_res_t                         res_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int SMW = SQW + 2;
  localparam int R2W = 2 * RADIUS_BITS;

  function automatic logic [DW-1:0] abs_diff(logic signed [COORD_BITS-1:0] p,
                                             logic signed [COORD_BITS-1:0] c);
    logic [DW-1:0] d;
    d = {p[COORD_BITS-1], p} - {c[COORD_BITS-1], c};
    return d[DW-1] ? (~d + DW'(1)) : d;
  endfunction

  stage_t             a_q, b_q;
  logic [DW-1:0]      dx_q, dy_q, dz_q;
  logic [RADIUS_BITS-1:0] r_q;
  logic [SQW-1:0]     sqx_q, sqy_q, sqz_q;
  logic [R2W-1:0]     r2_q;
  logic [SMW-1:0]     sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (flush_i) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q <= in_i;
      b_q <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= abs_diff(px_i, sphere_i.cx);
    dy_q  <= abs_diff(py_i, sphere_i.cy);
    dz_q  <= abs_diff(pz_i, sphere_i.cz);
    r_q   <= sphere_i.r;
    sqx_q <= SQW'(dx_q) * SQW'(dx_q);
    sqy_q <= SQW'(dy_q) * SQW'(dy_q);
    sqz_q <= SQW'(dz_q) * SQW'(dz_q);
    r2_q  <= R2W'(r_q) * R2W'(r_q);
  end

  assign sum = SMW'(sqx_q) + SMW'(sqy_q) + SMW'(sqz_q);

  always_comb begin
    res_o.valid   = b_q.valid;
    res_o.hit     = b_q.valid && (sum <= SMW'(r2_q));
    res_o.tag     = b_q.tag;
    res_o.pending = a_q.valid || b_q.valid;
  end

endmodule

`default_nettype wire

[hw/rtl/point_in_sphere_union_counter.sv]
// ----------------------------------------------------------------------------
// point_in_sphere_union_counter
// sphere table in ram, point tests scanned slot by slot, saturating counts
// ----------------------------------------------------------------------------
// load, clear: result strobe in the cycle after start, one item per cycle
// test: one table read per cycle through a three-stage ram and distance pipe;
//   the scan ends at the first hit or once all slots in use are tested (slots in
//   use = sphere_count, at most MAX_SPHERES); busy drops with the result strobe
// reset: counts and sphere_count cleared at once; the table is not cleared
// the result strobe cannot be stalled by the receiver
`default_nettype none
`include "assert_macros.svh"

module point_in_sphere_union_counter
  import pisuc_pkg::*;
#(
  parameter int MAX_SPHERES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire item_t              item_i,
  output logic                    done_o,
  output result_t                 result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int NW = ($clog2(MAX_SPHERES + 1) > CFG_W) ? $clog2(MAX_SPHERES + 1) : CFG_W;
  localparam int SLOTS = 2 ** SLOT_W;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        count_q;
  logic [NW-1:0]           n_q, n_d, issue_cnt_q, issue_cnt_d;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  stage_t                  s1_q, s1_d;
  logic [CNT_W-1:0]        hits_q, hits_d, points_q, points_d;
  logic                    done_q, done_d;
  result_t                 res_q, res_d;

  logic                    accept, we, rd_en, flush, found, exhausted;
  logic [NW-1:0]           n_req;
  logic [AW-1:0]           slot_mod [SLOTS];
  sphere_t                 wr_entry, rd_entry;
  dist_res_t               dres;

  // slot wraps over the table depth
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot_mod
    assign slot_mod[i] = AW'(i % MAX_SPHERES);
  end

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign we     = accept && (item_i.action == ActLoad);

  assign wr_entry.cx = item_i.coord_x;
  assign wr_entry.cy = item_i.coord_y;
  assign wr_entry.cz = item_i.coord_z;
  assign wr_entry.r  = item_i.radius;

  assign n_req = (NW'(count_q) > NW'(MAX_SPHERES)) ? NW'(MAX_SPHERES) : NW'(count_q);

  pisuc_ram #(
    .WIDTH ($bits(sphere_t)),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_mod[item_i.slot]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (issue_cnt_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  pisuc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (flush),
    .in_i     (s1_q),
    .sphere_i (rd_entry),
    .px_i     (px_q),
    .py_i     (py_q),
    .pz_i     (pz_q),
    .res_o    (dres)
  );

  assign found     = dres.valid && dres.hit;
  assign exhausted = (issue_cnt_q == n_q) && !s1_q.valid && !dres.pending;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    issue_cnt_d = issue_cnt_q;
    s1_d        = '0;
    hits_d      = hits_q;
    points_d    = points_q;
    done_d      = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    flush       = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (item_i.action)
            ActTest: begin
              n_d         = n_req;
              issue_cnt_d = '0;
              state_d     = StScan;
            end
            ActClear: begin
              hits_d   = '0;
              points_d = '0;
              done_d   = 1'b1;
              res_d    = '{inside_res: 1'b0, hit_slot: '0, hit_count: '0, point_count: '0};
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{inside_res: 1'b0, hit_slot: '0,
                         hit_count: hits_q, point_count: points_q};
            end
          endcase
        end
      end
      StScan: begin
        if (found || exhausted) begin
          points_d = (points_q == '1) ? points_q : points_q + CNT_W'(1);
          if (found && (hits_q != '1)) begin
            hits_d = hits_q + CNT_W'(1);
          end
          done_d  = 1'b1;
          res_d   = '{inside_res: found, hit_slot: found ? dres.tag : '0,
                      hit_count: hits_d, point_count: points_d};
          flush   = 1'b1;
          state_d = StIdle;
        end else if (issue_cnt_q < n_q) begin
          rd_en       = 1'b1;
          s1_d.valid  = 1'b1;
          s1_d.tag    = issue_cnt_q[SLOT_W-1:0];
          issue_cnt_d = issue_cnt_q + NW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      issue_cnt_q <= '0;
      s1_q        <= '0;
      hits_q      <= '0;
      points_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      issue_cnt_q <= issue_cnt_d;
      s1_q        <= s1_d;
      hits_q      <= hits_d;
      points_q    <= points_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      px_q <= item_i.coord_x;
      py_q <= item_i.coord_y;
      pz_q <= item_i.coord_z;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegSphereCount)) begin
      count_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSphereCount) ? PDATA_W'(count_q) : '0;

  `ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni, done_q && busy, "result beat while scanning")
  `ASSERT_NEVER(a_hits_le_points, clk_i, rst_ni, hits_q > points_q, "hit count above point count")
  `ASSERT_CHK(a_issue_bound, clk_i, rst_ni, (state_q == StScan) |-> (issue_cnt_q <= n_q), "scan past slots in use")
  `ASSERT_CHK(a_hit_counted, clk_i, rst_ni, (done_q && res_q.inside_res) |-> (res_q.hit_count != '0), "hit reported with zero hit count")

endmodule

`default_nettype wire
